>>> sv/hbp_pkg.sv
package hbp_pkg;

  // Fixed field widths of the command and result beats.
  localparam int OP_W       = 2;
  localparam int SYM_W      = 8;
  localparam int WORD_W     = 32;
  localparam int LEN_PORT_W = 6;
  localparam int BYTE_W     = 8;
  localparam int TAIL_W     = 3;
  localparam int PEND_W     = 7;

  // Defaults for the top-level parameters.
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_COUNT_DEF = 256;

  // Command codes.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

endpackage

>>> sv/hbp_cmd_if.sv
interface hbp_cmd_if import hbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       opcode;
  logic [SYM_W-1:0]      symbol;
  logic [WORD_W-1:0]     code_word;
  logic [LEN_PORT_W-1:0] code_length;

  modport source (output valid, output opcode, output symbol, output code_word,
                  output code_length, input ready);
  modport sink   (input valid, input opcode, input symbol, input code_word,
                  input code_length, output ready);
endinterface

>>> sv/hbp_res_if.sv
interface hbp_res_if import hbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [TAIL_W-1:0] tail_bits;
  logic              is_tail;
  logic              last;

  modport source (output valid, output out_byte, output tail_bits, output is_tail,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input tail_bits, input is_tail,
                  input last, output ready);
endinterface

>>> sv/huffman_bit_packer.sv
// A result beat comes from the output buffer, which a command reaches via the stage 1 registers.
// Throughput: one command per cycle while each command yields at most one byte and the receiver is ready;
// an encode that yields n bytes holds stage 1 until they drain, one byte per cycle while ready.
// The code table is one synchronous memory port: one read or one write per command.
// Reset (synchronous, rst high) clears the per-entry valid bits, the bit accumulator
// and the pipeline at once; an entry never loaded reads as length zero.
module huffman_bit_packer import hbp_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input logic      clk,
  input logic      rst,
  hbp_cmd_if.sink  cmd,
  hbp_res_if.source res
);

  localparam int CAP_LEN = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
  localparam int LEN_W   = $clog2(CAP_LEN + 1);
  localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ENTRY_W = CAP_LEN + LEN_W;
  localparam int ACC_W   = PEND_W + CAP_LEN;
  localparam int MAX_OUT = ACC_W / BYTE_W;
  localparam int TOT_W   = $clog2(ACC_W + 1);
  localparam int CNT_W   = $clog2(MAX_OUT + 1);
  localparam int IDX_W   = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);

  // Code table and its per-entry valid bits.
  logic [ENTRY_W-1:0] code_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] tbl_vld;

  // Stage 1 registers.
  logic               s1_valid;
  op_t                s1_op;
  logic               s1_hit;
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_vld;

  // Bit accumulator.
  logic [PEND_W-1:0] pbits, pbits_next;
  logic [2:0]        pcnt, pcnt_next;

  // Output byte buffer.
  logic [BYTE_W-1:0] eb_byte [MAX_OUT];
  logic [CNT_W-1:0]  eb_left;
  logic [IDX_W-1:0]  eb_idx;
  logic              eb_tail;
  logic [TAIL_W-1:0] eb_tbits;

  logic              cmd_fire, res_fire, eb_free, s1_go;
  logic              sym_ok, mem_we;
  logic [ADDR_W-1:0] addr;
  logic [LEN_W-1:0]  ld_len;
  logic [CAP_LEN-1:0] ld_mask, ld_word;

  logic [LEN_W-1:0]   enc_len;
  logic [CAP_LEN-1:0] enc_word;
  logic [ACC_W-1:0]   enc_acc, enc_align;
  logic [TOT_W-1:0]   enc_total;
  logic [BYTE_W-1:0]  fl_byte;

  logic [CNT_W-1:0]  new_n;
  logic [BYTE_W-1:0] new_byte [MAX_OUT];
  logic              new_tail;
  logic [TAIL_W-1:0] new_tbits;

  // Handshake and stage advance.
  assign res_fire  = res.valid && res.ready;
  assign eb_free   = (eb_left == '0) || ((eb_left == CNT_W'(1)) && res.ready);
  assign s1_go     = s1_valid && eb_free;
  assign cmd.ready = !s1_valid || s1_go;
  assign cmd_fire  = cmd.valid && cmd.ready;

  // Load path: saturate the length and drop the code bits above it.
  assign sym_ok  = {1'b0, cmd.symbol} < SYM_LIMIT;
  assign addr    = cmd.symbol[ADDR_W-1:0];
  assign mem_we  = cmd_fire && (op_t'(cmd.opcode) == OP_LOAD) && sym_ok;
  always_comb begin
    if (cmd.code_length > LEN_PORT_W'(CAP_LEN)) begin
      ld_len = LEN_W'(CAP_LEN);
    end else begin
      ld_len = cmd.code_length[LEN_W-1:0];
    end
  end
  assign ld_mask = ~({CAP_LEN{1'b1}} << ld_len);
  assign ld_word = cmd.code_word[CAP_LEN-1:0] & ld_mask;

  // Table memory: one write on an in-range load, one registered read on any other beat.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      code_mem[addr] <= {ld_len, ld_word};
    end else if (cmd_fire) begin
      rd_data <= code_mem[addr];
    end
  end

  // Valid bits and the looked-up entry's valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (mem_we) begin
        tbl_vld[addr] <= 1'b1;
      end
      if (cmd_fire) begin
        rd_vld <= tbl_vld[addr];
      end
    end
  end

  // Stage 1 control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1_op  <= op_t'(cmd.opcode);
      s1_hit <= sym_ok;
    end
  end

  // Encode: append the code below the pending bits and left-align the result.
  assign enc_len   = (s1_hit && rd_vld) ? rd_data[ENTRY_W-1 -: LEN_W] : '0;
  assign enc_word  = (s1_hit && rd_vld) ? rd_data[CAP_LEN-1:0] : '0;
  assign enc_acc   = ({{CAP_LEN{1'b0}}, pbits} << enc_len) | {{PEND_W{1'b0}}, enc_word};
  assign enc_total = TOT_W'(pcnt) + TOT_W'(enc_len);
  assign enc_align = enc_acc << (TOT_W'(ACC_W) - enc_total);

  // Flush: pad the pending bits with zeros up to the byte boundary.
  assign fl_byte = BYTE_W'({1'b0, pbits} << (4'(BYTE_W) - {1'b0, pcnt}));

  // Results of the command in stage 1 and the next accumulator state.
  always_comb begin
    new_n      = '0;
    new_tail   = 1'b0;
    new_tbits  = '0;
    pbits_next = pbits;
    pcnt_next  = pcnt;
    for (int k = 0; k < MAX_OUT; k++) begin
      new_byte[k] = enc_align[ACC_W-1-BYTE_W*k -: BYTE_W];
    end
    unique case (s1_op)
      OP_ENCODE: begin
        if (enc_len != '0) begin
          new_n      = CNT_W'(enc_total >> 3);
          pcnt_next  = enc_total[2:0];
          pbits_next = enc_acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << enc_total[2:0]);
        end
      end
      OP_FLUSH: begin
        if (pcnt != '0) begin
          new_n       = CNT_W'(1);
          new_byte[0] = fl_byte;
          new_tail    = 1'b1;
          new_tbits   = pcnt;
          pbits_next  = '0;
          pcnt_next   = '0;
        end
      end
      default: begin
        new_n = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pbits <= '0;
      pcnt  <= '0;
    end else if (s1_go) begin
      pbits <= pbits_next;
      pcnt  <= pcnt_next;
    end
  end

  // Output buffer: loaded with all bytes of one command, drained one beat a cycle while the receiver is ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      eb_left <= '0;
      eb_idx  <= '0;
    end else if (s1_go && (new_n != '0)) begin
      eb_left <= new_n;
      eb_idx  <= '0;
    end else if (res_fire) begin
      eb_left <= eb_left - CNT_W'(1);
      eb_idx  <= eb_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (new_n != '0)) begin
      eb_byte  <= new_byte;
      eb_tail  <= new_tail;
      eb_tbits <= new_tbits;
    end
  end

  assign res.valid     = eb_left != '0;
  assign res.out_byte  = eb_byte[eb_idx];
  assign res.tail_bits = eb_tbits;
  assign res.is_tail   = eb_tail;
  assign res.last      = eb_left == CNT_W'(1);

endmodule

>>> tb/sv/tb_huffman_bit_packer.sv
`timescale 1ns / 100ps

module tb_huffman_bit_packer;
  import hbp_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 420;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 20;
  localparam int SYM_POOL_TOP = 15;

  // The one command code that the package leaves unnamed.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One byte beat as it leaves the packer.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [TAIL_W-1:0] tail;
    logic              is_tail;
    logic              last;
  } byte_beat_t;

  // Keeps its own code table and bit accumulator and the queue of byte beats still owed.
  class packer_scoreboard;
    logic [WORD_W-1:0]     code_words [SYMBOL_COUNT_DEF];
    logic [LEN_PORT_W-1:0] code_lens  [SYMBOL_COUNT_DEF];
    logic [PEND_W-1:0]     acc_bits;
    logic [TAIL_W-1:0]     acc_count;
    byte_beat_t            owed_bytes[$];
    int                    mismatches;

    function new();
      foreach (code_lens[i]) begin
        code_lens[i]  = '0;
        code_words[i] = '0;
      end
      acc_bits   = '0;
      acc_count  = '0;
      mismatches = 0;
    endfunction

    function int owed();
      return owed_bytes.size();
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 20) $display("%0t mismatch: %s", $time, what);
    endtask

    // Work out the byte beats that one accepted command beat causes.
    function void note_cmd(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [WORD_W-1:0] word, input logic [LEN_PORT_W-1:0] len);
      logic [63:0]           acc;
      logic [LEN_PORT_W-1:0] cut;
      int                    total;
      int                    cap;
      int                    first;
      byte_beat_t            b;
      cap = (MAX_CODE_LEN_DEF < WORD_W) ? MAX_CODE_LEN_DEF : WORD_W;
      case (op)
        OP_LOAD: begin
          if (int'(sym) < SYMBOL_COUNT_DEF) begin
            cut = (int'(len) > cap) ? LEN_PORT_W'(cap) : len;
            code_lens[sym]  = cut;
            code_words[sym] = WORD_W'({32'd0, word} & ((64'd1 << cut) - 64'd1));
          end
        end
        OP_ENCODE: begin
          if (int'(sym) < SYMBOL_COUNT_DEF && code_lens[sym] != 0) begin
            acc   = ({57'd0, acc_bits} << code_lens[sym]) | {32'd0, code_words[sym]};
            total = int'(acc_count) + int'(code_lens[sym]);
            first = owed_bytes.size();
            while (total >= BYTE_W) begin
              b.data    = BYTE_W'(acc >> (total - BYTE_W));
              b.tail    = '0;
              b.is_tail = 1'b0;
              b.last    = 1'b0;
              owed_bytes = {owed_bytes, b};
              total -= BYTE_W;
            end
            if (owed_bytes.size() > first) owed_bytes[owed_bytes.size() - 1].last = 1'b1;
            acc_count = TAIL_W'(total);
            acc_bits  = PEND_W'(acc & ((64'd1 << total) - 64'd1));
          end
        end
        OP_FLUSH: begin
          // Pad to the byte boundary only; nothing when the accumulator is empty.
          if (acc_count != 0) begin
            b.data    = BYTE_W'({1'b0, acc_bits} << (BYTE_W - int'(acc_count)));
            b.tail    = acc_count;
            b.is_tail = 1'b1;
            b.last    = 1'b1;
            owed_bytes = {owed_bytes, b};
            acc_bits  = '0;
            acc_count = '0;
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted byte beat with the oldest one owed.
    task check_beat(input byte_beat_t got);
      byte_beat_t want;
      if (owed_bytes.size() == 0) begin
        report_mismatch($sformatf("byte beat %h with none owed", got.data));
      end else begin
        want = owed_bytes.pop_front();
        if (got.data !== want.data)
          report_mismatch($sformatf("out_byte %h, wanted %h", got.data, want.data));
        if (got.tail !== want.tail)
          report_mismatch($sformatf("tail_bits %0d, wanted %0d", got.tail, want.tail));
        if (got.is_tail !== want.is_tail)
          report_mismatch($sformatf("is_tail %b, wanted %b", got.is_tail, want.is_tail));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, wanted %b", got.last, want.last));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  bit   idle_en;
  int   rx_hold_req;

  packer_scoreboard sb;
  byte_beat_t       seen_beat;

  hbp_cmd_if cmd_bus ();
  hbp_res_if res_bus ();

  huffman_bit_packer #(
    .MAX_CODE_LEN (MAX_CODE_LEN_DEF),
    .SYMBOL_COUNT (SYMBOL_COUNT_DEF)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Run limit.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Note every accepted command beat, then check every accepted byte beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_bus.valid && cmd_bus.ready)
        sb.note_cmd(cmd_bus.opcode, cmd_bus.symbol, cmd_bus.code_word, cmd_bus.code_length);
      if (res_bus.valid && res_bus.ready) begin
        seen_beat.data    = res_bus.out_byte;
        seen_beat.tail    = res_bus.tail_bits;
        seen_beat.is_tail = res_bus.is_tail;
        seen_beat.last    = res_bus.last;
        sb.check_beat(seen_beat);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here when asked for.
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (idle_en) begin
        res_bus.ready <= ($urandom_range(0, 99) >= 36);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Offer one command beat, after a random gap, and wait until it is taken.
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                          input logic [WORD_W-1:0] word, input logic [LEN_PORT_W-1:0] len);
    while (idle_en && $urandom_range(0, 99) < 36) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.opcode      <= op;
    cmd_bus.symbol      <= sym;
    cmd_bus.code_word   <= word;
    cmd_bus.code_length <= len;
    do @(posedge clk); while (!cmd_bus.ready);
  endtask

  // Hold the sender back until every owed byte beat has come.
  task automatic wait_drain();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed() != 0) @(posedge clk);
  endtask

  // Mostly loads and encodes over a small set of symbols, so codes stay mapped;
  // the rest hits unmapped symbols, flushes and the unused command code.
  task automatic send_random_item();
    int                    pick;
    logic [SYM_W-1:0]      sym;
    logic [LEN_PORT_W-1:0] len;
    pick = $urandom_range(0, 99);
    sym  = ($urandom_range(0, 3) == 0) ? SYM_W'($urandom) : SYM_W'($urandom_range(0, SYM_POOL_TOP));
    if (pick < 18) begin
      len = ($urandom_range(0, 9) == 0) ? LEN_PORT_W'($urandom) : LEN_PORT_W'($urandom_range(1, 32));
      send_cmd(OP_LOAD, sym, $urandom, len);
    end else if (pick < 82) begin
      send_cmd(OP_ENCODE, sym, $urandom, LEN_PORT_W'($urandom));
    end else if (pick < 96) begin
      send_cmd(OP_FLUSH, sym, $urandom, LEN_PORT_W'($urandom));
    end else begin
      send_cmd(OP_UNUSED, sym, $urandom, LEN_PORT_W'($urandom));
    end
  endtask

  initial begin
    sb          = new();
    idle_en     = 1'b1;
    rx_hold_req = 0;
    rst                 <= 1'b1;
    cmd_bus.valid       <= 1'b0;
    cmd_bus.opcode      <= OP_LOAD;
    cmd_bus.symbol      <= '0;
    cmd_bus.code_word   <= '0;
    cmd_bus.code_length <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Nothing mapped yet, nothing pending, and the unused code: all silent.
    send_cmd(OP_ENCODE, 8'd0, 32'hFFFF_FFFF, 6'd63);
    send_cmd(OP_FLUSH, 8'd255, 32'hFFFF_FFFF, 6'd63);
    send_cmd(OP_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63);

    // Table loads: full width, zero length, overlong lengths, bits above the length.
    send_cmd(OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
    send_cmd(OP_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);
    send_cmd(OP_LOAD, 8'd1, 32'h0000_0016, 6'd5);
    send_cmd(OP_LOAD, 8'd2, 32'h0000_0001, 6'd1);
    send_cmd(OP_LOAD, 8'd3, 32'hA5A5_5A5A, 6'd63);
    send_cmd(OP_LOAD, 8'd4, 32'hFFFF_FFFF, 6'd33);
    send_cmd(OP_LOAD, 8'd5, 32'hFFFF_FF03, 6'd3);
    send_cmd(OP_LOAD, 8'd6, 32'h0000_007F, 6'd7);

    // Encodes of none, one and four bytes, zero length codes, and flushes.
    send_cmd(OP_ENCODE, 8'd255, '0, '0);
    send_cmd(OP_ENCODE, 8'd1, '0, '0);
    send_cmd(OP_ENCODE, 8'd255, '0, '0);
    send_cmd(OP_FLUSH, '0, '0, '0);
    send_cmd(OP_ENCODE, 8'd2, '0, '0);
    send_cmd(OP_ENCODE, 8'd3, '0, '0);
    send_cmd(OP_ENCODE, 8'd0, '0, '0);
    send_cmd(OP_FLUSH, '0, '0, '0);
    send_cmd(OP_FLUSH, '0, '0, '0);
    send_cmd(OP_ENCODE, 8'd5, '0, '0);
    send_cmd(OP_ENCODE, 8'd4, '0, '0);
    send_cmd(OP_ENCODE, 8'd6, '0, '0);
    send_cmd(OP_ENCODE, 8'd255, '0, '0);
    send_cmd(OP_FLUSH, '0, '0, '0);

    // Random part, with a long receiver hold-off, a stretch with no idling,
    // and one pause of the sender until the packer has drained.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) rx_hold_req = HOLD_CYCLES;
      if (i == 150) idle_en = 1'b0;
      if (i == 250) idle_en = 1'b1;
      if (i == 300) wait_drain();
      send_random_item();
    end
    cmd_bus.valid <= 1'b0;
    @(posedge clk);

    while (sb.owed() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.owed() != 0)
      sb.report_mismatch($sformatf("%0d byte beats never came", sb.owed()));

    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
